>>> src/pstam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstam_pkg
// Shared types, constants and hash helpers of the traffic anomaly monitor.
// ----------------------------------------------------------------------------
package pstam_pkg;

    localparam int FLOW_SLOTS_DEF  = 1024;
    localparam int DEST_SLOTS_DEF  = 1024;
    localparam int PROBE_LIMIT_DEF = 8;

    // widest slot index any legal table size needs
    localparam int IDX_MAX_W   = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  PROTO_TCP          = 8'd6;
    localparam logic [7:0]  PROTO_UDP          = 8'd17;
    localparam logic [5:0]  MIN_HDR_BYTES      = 6'd20;
    localparam logic [16:0] ETH_BYTES          = 17'd14;
    localparam logic [16:0] UDP_HDR_BYTES      = 17'd8;
    localparam logic [3:0]  ALERT_FACTOR_RESET = 4'd3;
    localparam logic [31:0] MIX_MULT           = 32'h7FEB352D;
    localparam logic [31:0] MAX32              = 32'hFFFF_FFFF;
    localparam logic [39:0] MAX40              = 40'hFF_FFFF_FFFF;
    localparam logic [10:0] MAX11              = 11'h7FF;

    // register index (paddr[2])
    localparam logic REG_ALERT_FACTOR = 1'b0;

    typedef struct packed {
        logic [31:0] time_second;
        logic [15:0] capture_length;
        logic [3:0]  ip_header_words;
        logic [7:0]  ip_protocol;
        logic [15:0] ip_total_length;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [3:0]  tcp_offset_words;
    } t_item;

    typedef struct packed {
        logic [31:0] report_number;
        logic        is_alert;
        logic [31:0] packet_total;
        logic [39:0] byte_total;
        logic [10:0] flow_total;
        logic        alert_packets;
        logic        alert_bytes;
        logic        alert_flows;
        logic [31:0] top_destination;
        logic        top_valid;
        logic        table_overflow;
    } t_report;

    // classified word handed from front to back
    typedef struct packed {
        logic                 counted;
        logic                 report;
        logic                 tcp;
        logic [31:0]          src;
        logic [31:0]          dst;
        logic [15:0]          sport;
        logic [15:0]          dport;
        logic [15:0]          tot;
        logic [IDX_MAX_W-1:0] fbase;
        logic [IDX_MAX_W-1:0] dbase;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_MOD,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_FCMP,
        B_DCMP,
        B_REPORT
    } t_bstate;

    // first half of the mixer: fold and multiply
    function automatic logic [31:0] mix_pre(input logic [31:0] x);
        logic [31:0] f;
        f = x ^ (x >> 16);
        return f * MIX_MULT;
    endfunction

    // second half: fold the product
    function automatic logic [31:0] mix_post(input logic [31:0] p);
        return p ^ (p >> 15);
    endfunction

endpackage

>>> src/pstam_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstam_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pstam_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/pstam_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstam_front
// Accepts headers, checks lengths, hashes the 5-tuple and destination,
// reduces both hashes to slot numbers and queues the classified word.
// ----------------------------------------------------------------------------
module pstam_front #(
    parameter int FLOW_SLOTS = pstam_pkg::FLOW_SLOTS_DEF,
    parameter int DEST_SLOTS = pstam_pkg::DEST_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  pstam_pkg::t_item         i_item,
    input  pstam_pkg::t_queue_status i_queue,
    output logic                     o_push,
    output pstam_pkg::t_task         o_task,
    output logic                     o_busy
);
    import pstam_pkg::*;

    localparam int FIW = $clog2(FLOW_SLOTS);
    localparam int DIW = $clog2(DEST_SLOTS);

    t_fstate        r_state, n_state;
    logic [1:0]     r_step, n_step;
    t_item          r_item, n_item;
    logic [31:0]    r_second, n_second;
    logic           r_counted, n_counted;
    logic           r_report, n_report;
    logic [31:0]    r_prod, n_prod;
    logic [31:0]    r_dprod, n_dprod;
    logic [31:0]    r_fh, n_fh;
    logic [31:0]    r_dh, n_dh;
    logic [FIW-1:0] r_frem, n_frem;
    logic [DIW-1:0] r_drem, n_drem;

    logic           is_tcp;
    logic           hdr_ok;
    logic           valid_now;

    always_comb begin
        hdr_ok = ({i_item.ip_header_words, 2'b00} >= MIN_HDR_BYTES);
        valid_now = 1'b0;
        if (hdr_ok) begin
            if (i_item.ip_protocol == PROTO_UDP) begin
                valid_now = {1'b0, i_item.capture_length} >=
                            ETH_BYTES + {11'd0, i_item.ip_header_words, 2'b00} + UDP_HDR_BYTES;
            end else if (i_item.ip_protocol == PROTO_TCP) begin
                valid_now = {i_item.tcp_offset_words, 2'b00} >= MIN_HDR_BYTES;
            end
        end
    end

    assign is_tcp = (r_item.ip_protocol == PROTO_TCP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_second <= '0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
        r_step    <= n_step;
        r_item    <= n_item;
        r_counted <= n_counted;
        r_report  <= n_report;
        r_prod    <= n_prod;
        r_dprod   <= n_dprod;
        r_fh      <= n_fh;
        r_dh      <= n_dh;
        r_frem    <= n_frem;
        r_drem    <= n_drem;
    end

    always_comb begin
        logic [31:0] a;
        logic [31:0] fsrc;
        logic [31:0] dsrc;
        logic [FIW:0] fr;
        logic [DIW:0] dr;

        n_state   = r_state;
        n_step    = r_step;
        n_item    = r_item;
        n_second  = r_second;
        n_counted = r_counted;
        n_report  = r_report;
        n_prod    = r_prod;
        n_dprod   = r_dprod;
        n_fh      = r_fh;
        n_dh      = r_dh;
        n_frem    = r_frem;
        n_drem    = r_drem;
        o_push    = 1'b0;
        a         = '0;
        fsrc      = r_fh;
        dsrc      = r_dh;
        fr        = '0;
        dr        = '0;

        unique case (r_state)
            F_IDLE: begin
                if (i_accept) begin
                    n_item    = i_item;
                    n_counted = valid_now;
                    n_report  = (i_item.time_second != r_second);
                    n_second  = i_item.time_second;
                    n_step    = '0;
                    n_frem    = '0;
                    n_drem    = '0;
                    n_state   = valid_now ? F_HASH : F_PUSH;
                end
            end
            F_HASH: begin
                // one mixer round per cycle, chained through r_prod
                unique case (r_step)
                    2'd0: a = r_item.source_address;
                    2'd1: a = mix_post(r_prod) ^ r_item.dest_address;
                    2'd2: a = mix_post(r_prod) ^ {r_item.source_port, r_item.dest_port};
                    default: a = mix_post(r_prod) ^ {31'd0, is_tcp};
                endcase
                n_prod = mix_pre(a);
                if (r_step == 2'd0) begin
                    n_dprod = mix_pre(r_item.dest_address);
                end
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = F_MOD;
                end
            end
            F_MOD: begin
                // remainder by slot count, eight bits a cycle, MSB first
                if (r_step == 2'd0) begin
                    fsrc = mix_post(r_prod);
                    dsrc = mix_post(r_dprod);
                end
                fr = {1'b0, r_frem};
                dr = {1'b0, r_drem};
                for (int j = 0; j < 8; j++) begin
                    fr = {fr[FIW-1:0], fsrc[31-j]};
                    if (fr >= (FIW+1)'(FLOW_SLOTS)) begin
                        fr = fr - (FIW+1)'(FLOW_SLOTS);
                    end
                    dr = {dr[DIW-1:0], dsrc[31-j]};
                    if (dr >= (DIW+1)'(DEST_SLOTS)) begin
                        dr = dr - (DIW+1)'(DEST_SLOTS);
                    end
                end
                n_frem = fr[FIW-1:0];
                n_drem = dr[DIW-1:0];
                n_fh   = fsrc << 8;
                n_dh   = dsrc << 8;
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_queue.full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_task.counted = r_counted;
        o_task.report  = r_report;
        o_task.tcp     = is_tcp;
        o_task.src     = r_item.source_address;
        o_task.dst     = r_item.dest_address;
        o_task.sport   = r_item.source_port;
        o_task.dport   = r_item.dest_port;
        o_task.tot     = r_item.ip_total_length;
        o_task.fbase   = IDX_MAX_W'(r_frem);
        o_task.dbase   = IDX_MAX_W'(r_drem);
    end

    assign o_busy = (r_state != F_IDLE);
endmodule

>>> src/pstam_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstam_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module pstam_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  pstam_pkg::t_task         i_task,
    input  logic                     i_pop,
    output pstam_pkg::t_task         o_task,
    output pstam_pkg::t_queue_status o_status
);
    import pstam_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    t_task       r_slot [QUEUE_DEPTH];
    logic [QW-1:0] r_wr, r_rd;
    logic [QW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (QW+1)'(i_push) - (QW+1)'(i_pop);
        end
        if (i_push) begin
            r_slot[r_wr] <= i_task;
        end
    end

    assign o_task         = r_slot[r_rd];
    assign o_status.full  = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
endmodule

>>> src/pstam_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstam_back
// Counts, probes the flow and destination tables, tracks the top
// destination and closes each second with a report and a flow table sweep.
// ----------------------------------------------------------------------------
module pstam_back #(
    parameter int FLOW_SLOTS  = pstam_pkg::FLOW_SLOTS_DEF,
    parameter int DEST_SLOTS  = pstam_pkg::DEST_SLOTS_DEF,
    parameter int PROBE_LIMIT = pstam_pkg::PROBE_LIMIT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [3:0]               i_alert_factor,
    input  pstam_pkg::t_task         i_task,
    input  pstam_pkg::t_queue_status i_queue,
    output logic                     o_pop,
    output logic                     o_clearing,
    output logic                     o_report_valid,
    output pstam_pkg::t_report       o_report
);
    import pstam_pkg::*;

    localparam int FIW  = $clog2(FLOW_SLOTS);
    localparam int DIW  = $clog2(DEST_SLOTS);
    localparam int MAXS = (FLOW_SLOTS > DEST_SLOTS) ? FLOW_SLOTS : DEST_SLOTS;
    localparam int CW   = $clog2(MAXS);
    localparam int PW   = $clog2(PROBE_LIMIT + 1);
    localparam int FW   = 98;   // valid, src/dst, tcp/ports
    localparam int DW   = 65;   // valid, address, count

    t_bstate        r_state, n_state;
    t_task          r_task, n_task;
    logic [FIW-1:0] r_fidx, n_fidx;
    logic [DIW-1:0] r_didx, n_didx;
    logic [PW-1:0]  r_probe, n_probe;
    logic [CW-1:0]  r_clr, n_clr;
    logic           r_clr_dest, n_clr_dest;
    logic [31:0]    r_pkts, n_pkts;
    logic [39:0]    r_bytes, n_bytes;
    logic [10:0]    r_flows, n_flows;
    logic [31:0]    r_prev_pkts, n_prev_pkts;
    logic [39:0]    r_prev_bytes, n_prev_bytes;
    logic [10:0]    r_prev_flows, n_prev_flows;
    logic [31:0]    r_rep_cnt, n_rep_cnt;
    logic [31:0]    r_top_count, n_top_count;
    logic [31:0]    r_top_addr, n_top_addr;
    logic           r_ovf, n_ovf;
    t_report        r_out, n_out;
    logic           r_out_valid, n_out_valid;

    logic           f_we, d_we;
    logic [FIW-1:0] f_waddr, f_raddr;
    logic [DIW-1:0] d_waddr, d_raddr;
    logic [FW-1:0]  f_wdata, f_rdata;
    logic [DW-1:0]  d_wdata, d_rdata;

    pstam_ram #(.W(FW), .D(FLOW_SLOTS)) u_flow_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (f_wdata),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    pstam_ram #(.W(DW), .D(DEST_SLOTS)) u_dest_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_CLEAR;
            r_clr        <= '0;
            r_clr_dest   <= 1'b1;
            r_pkts       <= '0;
            r_bytes      <= '0;
            r_flows      <= '0;
            r_prev_pkts  <= '0;
            r_prev_bytes <= '0;
            r_prev_flows <= '0;
            r_rep_cnt    <= '0;
            r_top_count  <= '0;
            r_top_addr   <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_clr_dest   <= n_clr_dest;
            r_pkts       <= n_pkts;
            r_bytes      <= n_bytes;
            r_flows      <= n_flows;
            r_prev_pkts  <= n_prev_pkts;
            r_prev_bytes <= n_prev_bytes;
            r_prev_flows <= n_prev_flows;
            r_rep_cnt    <= n_rep_cnt;
            r_top_count  <= n_top_count;
            r_top_addr   <= n_top_addr;
            r_ovf        <= n_ovf;
            r_out_valid  <= n_out_valid;
        end
        r_task  <= n_task;
        r_fidx  <= n_fidx;
        r_didx  <= n_didx;
        r_probe <= n_probe;
        r_out   <= n_out;
    end

    always_comb begin
        logic [40:0]    bsum;
        logic [96:0]    fkey;
        logic [FIW-1:0] fnext;
        logic [DIW-1:0] dnext;
        logic           done;
        logic [31:0]    cand;
        logic [31:0]    cnt1;
        logic [35:0]    pp;
        logic [43:0]    pb;
        logic [14:0]    pf;
        logic           ap, ab, af, quiet, alert;

        n_state      = r_state;
        n_task       = r_task;
        n_fidx       = r_fidx;
        n_didx       = r_didx;
        n_probe      = r_probe;
        n_clr        = r_clr;
        n_clr_dest   = r_clr_dest;
        n_pkts       = r_pkts;
        n_bytes      = r_bytes;
        n_flows      = r_flows;
        n_prev_pkts  = r_prev_pkts;
        n_prev_bytes = r_prev_bytes;
        n_prev_flows = r_prev_flows;
        n_rep_cnt    = r_rep_cnt;
        n_top_count  = r_top_count;
        n_top_addr   = r_top_addr;
        n_ovf        = r_ovf;
        n_out        = r_out;
        n_out_valid  = 1'b0;
        o_pop        = 1'b0;
        f_we         = 1'b0;
        f_waddr      = r_fidx;
        f_wdata      = '0;
        f_raddr      = r_fidx;
        d_we         = 1'b0;
        d_waddr      = r_didx;
        d_wdata      = '0;
        d_raddr      = r_didx;

        bsum  = '0;
        fkey  = {r_task.src, r_task.dst, r_task.tcp, r_task.sport, r_task.dport};
        fnext = (r_fidx == FIW'(FLOW_SLOTS - 1)) ? '0 : r_fidx + 1'b1;
        dnext = (r_didx == DIW'(DEST_SLOTS - 1)) ? '0 : r_didx + 1'b1;
        done  = 1'b0;
        cand  = 32'd1;
        cnt1  = '0;
        pp    = 36'(r_prev_pkts) * 36'(i_alert_factor);
        pb    = 44'(r_prev_bytes) * 44'(i_alert_factor);
        pf    = 15'(r_prev_flows) * 15'(i_alert_factor);
        ap    = pp <= 36'(r_pkts);
        ab    = pb <= 44'(r_bytes);
        af    = pf <= 15'(r_flows);
        quiet = (r_pkts == '0) && (r_bytes == '0) && (r_flows == '0) &&
                (r_prev_pkts == '0) && (r_prev_bytes == '0) && (r_prev_flows == '0);
        alert = !((!ap && !ab && !af) || quiet);

        unique case (r_state)
            B_CLEAR: begin
                f_waddr = r_clr[FIW-1:0];
                d_waddr = r_clr[DIW-1:0];
                f_we    = {1'b0, r_clr} < (CW+1)'(FLOW_SLOTS);
                d_we    = r_clr_dest && ({1'b0, r_clr} < (CW+1)'(DEST_SLOTS));
                if (r_clr == (r_clr_dest ? CW'(MAXS - 1) : CW'(FLOW_SLOTS - 1))) begin
                    n_state    = B_IDLE;
                    n_clr_dest = 1'b0;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            B_IDLE: begin
                if (!i_queue.empty) begin
                    o_pop  = 1'b1;
                    n_task = i_task;
                    if (i_task.counted) begin
                        n_pkts  = (r_pkts == MAX32) ? r_pkts : r_pkts + 32'd1;
                        bsum    = {1'b0, r_bytes} + 41'(i_task.tot);
                        n_bytes = (bsum > {1'b0, MAX40}) ? MAX40 : bsum[39:0];
                        f_raddr = i_task.fbase[FIW-1:0];
                        n_fidx  = i_task.fbase[FIW-1:0];
                        n_probe = '0;
                        n_state = B_FCMP;
                    end else if (i_task.report) begin
                        n_state = B_REPORT;
                    end
                end
            end
            B_FCMP: begin
                if (!f_rdata[FW-1]) begin
                    f_we    = 1'b1;
                    f_wdata = {1'b1, fkey};
                    n_flows = (r_flows == MAX11) ? r_flows : r_flows + 11'd1;
                    done    = 1'b1;
                end else if (f_rdata[96:0] == fkey) begin
                    done = 1'b1;
                end else if (r_probe == PW'(PROBE_LIMIT - 1)) begin
                    n_ovf = 1'b1;
                    done  = 1'b1;
                end else begin
                    n_fidx  = fnext;
                    f_raddr = fnext;
                    n_probe = r_probe + 1'b1;
                end
                if (done) begin
                    d_raddr = r_task.dbase[DIW-1:0];
                    n_didx  = r_task.dbase[DIW-1:0];
                    n_probe = '0;
                    n_state = B_DCMP;
                end
            end
            B_DCMP: begin
                if (!d_rdata[DW-1]) begin
                    d_we    = 1'b1;
                    d_wdata = {1'b1, r_task.dst, 32'd1};
                    done    = 1'b1;
                end else if (d_rdata[63:32] == r_task.dst) begin
                    cnt1    = (d_rdata[31:0] == MAX32) ? MAX32 : d_rdata[31:0] + 32'd1;
                    cand    = cnt1;
                    d_we    = 1'b1;
                    d_wdata = {1'b1, r_task.dst, cnt1};
                    done    = 1'b1;
                end else if (r_probe == PW'(PROBE_LIMIT - 1)) begin
                    // full: treated as a fresh destination that is not kept
                    n_ovf = 1'b1;
                    done  = 1'b1;
                end else begin
                    n_didx  = dnext;
                    d_raddr = dnext;
                    n_probe = r_probe + 1'b1;
                end
                if (done) begin
                    if (r_top_count <= cand) begin
                        n_top_count = cand;
                        n_top_addr  = r_task.dst;
                    end
                    n_state = r_task.report ? B_REPORT : B_IDLE;
                end
            end
            B_REPORT: begin
                n_rep_cnt                 = r_rep_cnt + 32'd1;
                n_out.report_number       = r_rep_cnt + 32'd1;
                n_out.is_alert            = alert;
                n_out.packet_total        = r_pkts;
                n_out.byte_total          = r_bytes;
                n_out.flow_total          = r_flows;
                n_out.alert_packets       = alert && ap;
                n_out.alert_bytes         = alert && ab;
                n_out.alert_flows         = alert && af;
                n_out.top_destination     = r_top_addr;
                n_out.top_valid           = (r_top_count != '0);
                n_out.table_overflow      = r_ovf;
                n_out_valid               = 1'b1;
                n_prev_pkts  = r_pkts;
                n_prev_bytes = r_bytes;
                n_prev_flows = r_flows;
                n_pkts       = '0;
                n_bytes      = '0;
                n_flows      = '0;
                n_top_count  = '0;
                n_top_addr   = '0;
                n_ovf        = 1'b0;
                n_clr        = '0;
                n_state      = B_CLEAR;
            end
            default: n_state = B_IDLE;
        endcase
    end

    assign o_clearing     = (r_state == B_CLEAR);
    assign o_report_valid = r_out_valid;
    assign o_report       = r_out;
endmodule

>>> src/per_second_traffic_anomaly_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_second_traffic_anomaly_monitor
// Per-second packet, byte and flow counting over parsed IPv4 headers, with
// a report and alert bits at every change of the timestamp second.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      word
//  item      in         i_start & !o_busy              i_item (t_item)
//  report    out        o_report_valid, one cycle      o_report (t_report)
//  config    in         psel & penable & pwrite        pwdata[3:0] at paddr 0
//
//  Front: an ignored header goes straight to the push state; a counted
//  one takes 4 mixer rounds (destination mixed beside the first) and 4
//  remainder steps. Back: a pop, then flow and destination probes, each
//  probe one read of a table RAM, 1..PROBE_LIMIT of each. A report is
//  followed by a flow table sweep; reset starts a sweep of both tables.
//  o_busy is high during sweeps and while the front holds a header.
//  Reports cannot be held off; the queue absorbs front/back skew.
// ----------------------------------------------------------------------------
module per_second_traffic_anomaly_monitor #(
    parameter int FLOW_SLOTS  = pstam_pkg::FLOW_SLOTS_DEF,
    parameter int DEST_SLOTS  = pstam_pkg::DEST_SLOTS_DEF,
    parameter int PROBE_LIMIT = pstam_pkg::PROBE_LIMIT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pstam_pkg::t_item   i_item,
    output logic               o_busy,
    output logic               o_report_valid,
    output pstam_pkg::t_report o_report,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pstam_pkg::*;

    logic [3:0]    r_factor;
    logic          front_busy, clearing, accept, push, pop;
    t_task         front_task, head_task;
    t_queue_status queue_status;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ALERT_FACTOR) ? {28'd0, r_factor} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= ALERT_FACTOR_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ALERT_FACTOR) begin
            r_factor <= pwdata[3:0];
        end
    end

    assign o_busy = front_busy || clearing;
    assign accept = i_start && !o_busy;

    pstam_front #(.FLOW_SLOTS(FLOW_SLOTS), .DEST_SLOTS(DEST_SLOTS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_item),
        .i_queue (queue_status),
        .o_push  (push),
        .o_task  (front_task),
        .o_busy  (front_busy)
    );

    pstam_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_task  (front_task),
        .i_pop   (pop),
        .o_task  (head_task),
        .o_status(queue_status)
    );

    pstam_back #(
        .FLOW_SLOTS (FLOW_SLOTS),
        .DEST_SLOTS (DEST_SLOTS),
        .PROBE_LIMIT(PROBE_LIMIT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_alert_factor(r_factor),
        .i_task        (head_task),
        .i_queue       (queue_status),
        .o_pop         (pop),
        .o_clearing    (clearing),
        .o_report_valid(o_report_valid),
        .o_report      (o_report)
    );

    // a report is always followed by the flow sweep
    a_report_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_report_valid |=> !o_report_valid && clearing)
        else $error("report not followed by flow sweep");

    a_alert_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_report_valid && (o_report.alert_packets || o_report.alert_bytes ||
                           o_report.alert_flows) |-> o_report.is_alert)
        else $error("alert bit in normal report");

    a_flow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_report_valid |-> ({6'd0, o_report.flow_total} <= 17'(FLOW_SLOTS)))
        else $error("more flows than slots");

    a_no_pop_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !pop)
        else $error("queue popped during sweep");
endmodule
